// File: rtl/smpq_pkg.sv
// Shared constants and types for the stable max-priority queue.
`default_nettype none
package smpq_pkg;
   localparam int CAPACITY_DEF      = 16;
   localparam int PRIORITY_BITS_DEF = 16;
   localparam int PAYLOAD_BITS_DEF  = 16;

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_PUSHED = 2'd0,
      STATUS_POPPED = 2'd1,
      STATUS_EMPTY  = 2'd2,
      STATUS_FULL   = 2'd3
   } status_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CMP   = 6'b000010,
      ST_PLACE = 6'b000100,
      ST_POPH  = 6'b001000,
      ST_SHIFT = 6'b010000,
      ST_RESP  = 6'b100000
   } state_type;
endpackage
`default_nettype wire

// File: rtl/stable_max_priority_queue_core.sv
// Top level: bounded max-priority queue with stable ties, kept sorted in one RAM.
//
// Usage:
//   req channel: tuser = func (0 push, 1 pop); tdata = priority (signed) in the
//   low bits, payload above it. Every item gives exactly one rsp item:
//   tuser = status (bits 1:0) and is_empty (bit 2); tdata = popped payload in
//   the low bits, then the entry count.
//   Entries sit in the RAM sorted in serving order, slot 0 first. A push walks
//   from the tail toward the head, moving each lower-priority entry up one
//   slot, one slot per cycle (one RAM read and one write per cycle). A pop
//   reads slot 0, then moves every remaining entry down one slot.
//   A refused push, an empty pop or a push into an empty queue goes straight
//   to ST_RESP; other pushes pass ST_CMP (and ST_PLACE on reaching slot 0),
//   other pops ST_POPH and, unless they take the last entry, ST_SHIFT. One item
//   is in work at a time; req_tready is high only while idle, in ST_IDLE.
//   A finished result waits in an output register; the next item is accepted
//   while it waits, and that item only stalls at its own end if the
//   receiver still holds rsp_tready low.
//   Reset (synchronous, active high) empties the queue at once; the RAM is
//   not cleared, because only occupied slots are ever read.
`default_nettype none
module stable_max_priority_queue_core
   import smpq_pkg::*;
#(
   parameter int CAPACITY      = CAPACITY_DEF,
   parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
   parameter int PAYLOAD_BITS  = PAYLOAD_BITS_DEF,
   localparam int AW    = $clog2(CAPACITY),
   localparam int CW    = $clog2(CAPACITY + 1),
   localparam int IN_W  = ((PRIORITY_BITS + PAYLOAD_BITS + 7) / 8) * 8,
   localparam int OUT_W = ((PAYLOAD_BITS + CW + 7) / 8) * 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [IN_W-1:0]  req_tdata,   // priority_req, payload
   input  wire logic             req_tuser,   // func
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic      [OUT_W-1:0] rsp_tdata,   // popped_payload, count
   output logic      [2:0]       rsp_tuser    // status, is_empty
);
   localparam int EW = PRIORITY_BITS + PAYLOAD_BITS;

   state_type                  state_ff, state_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic [AW-1:0]              idx_ff, idx_in;
   logic [PRIORITY_BITS-1:0]   prio_ff, prio_in;
   logic [PAYLOAD_BITS-1:0]    pay_ff, pay_in;
   logic [PAYLOAD_BITS-1:0]    popped_ff, popped_in;
   status_type                 status_ff, status_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [PAYLOAD_BITS-1:0]    rsp_pay_ff, rsp_pay_in;
   logic [CW-1:0]              rsp_cnt_ff, rsp_cnt_in;
   status_type                 rsp_status_ff, rsp_status_in;

   logic                       wr_en;
   logic [AW-1:0]              wr_addr, rd_addr;
   logic [EW-1:0]              wr_data, rd_data;
   logic [PRIORITY_BITS-1:0]   rd_prio;
   logic [PAYLOAD_BITS-1:0]    rd_pay;
   logic                       req_fire, rsp_free;

   assign rd_prio = rd_data[PRIORITY_BITS-1:0];
   assign rd_pay  = rd_data[EW-1:PRIORITY_BITS];

   smpq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      prio_in       = prio_ff;
      pay_in        = pay_ff;
      popped_in     = popped_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_pay_in    = rsp_pay_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = {pay_ff, prio_ff};
      rd_addr       = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               prio_in   = req_tdata[PRIORITY_BITS-1:0];
               pay_in    = req_tdata[EW-1:PRIORITY_BITS];
               popped_in = '0;
               if (req_tuser == FUNC_PUSH) begin
                  if (cnt_ff == CW'(CAPACITY)) begin
                     status_in = STATUS_FULL;
                     state_in  = ST_RESP;
                  end else if (cnt_ff == '0) begin
                     wr_en     = 1'b1;
                     wr_addr   = '0;
                     wr_data   = req_tdata[EW-1:0];
                     cnt_in    = CW'(1);
                     status_in = STATUS_PUSHED;
                     state_in  = ST_RESP;
                  end else begin
                     idx_in   = AW'(cnt_ff - CW'(1));
                     rd_addr  = AW'(cnt_ff - CW'(1));
                     state_in = ST_CMP;
                  end
               end else begin
                  if (cnt_ff == '0) begin
                     status_in = STATUS_EMPTY;
                     state_in  = ST_RESP;
                  end else begin
                     rd_addr  = '0;
                     state_in = ST_POPH;
                  end
               end
            end
         end
         ST_CMP: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff + AW'(1);
            if ($signed(rd_prio) < $signed(prio_ff)) begin
               // lower priority moves one slot toward the tail
               wr_data = rd_data;
               if (idx_ff == '0) begin
                  state_in = ST_PLACE;
               end else begin
                  idx_in  = idx_ff - AW'(1);
                  rd_addr = idx_ff - AW'(1);
               end
            end else begin
               cnt_in    = cnt_ff + CW'(1);
               status_in = STATUS_PUSHED;
               state_in  = ST_RESP;
            end
         end
         ST_PLACE: begin
            wr_en     = 1'b1;
            wr_addr   = '0;
            cnt_in    = cnt_ff + CW'(1);
            status_in = STATUS_PUSHED;
            state_in  = ST_RESP;
         end
         ST_POPH: begin
            popped_in = rd_pay;
            status_in = STATUS_POPPED;
            if (cnt_ff == CW'(1)) begin
               cnt_in   = '0;
               state_in = ST_RESP;
            end else begin
               idx_in   = AW'(1);
               rd_addr  = AW'(1);
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff - AW'(1);
            wr_data = rd_data;
            if (CW'(idx_ff) == cnt_ff - CW'(1)) begin
               cnt_in   = cnt_ff - CW'(1);
               state_in = ST_RESP;
            end else begin
               idx_in  = idx_ff + AW'(1);
               rd_addr = idx_ff + AW'(1);
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_pay_in    = popped_ff;
               rsp_cnt_in    = cnt_ff;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      prio_ff       <= prio_in;
      pay_ff        <= pay_in;
      popped_ff     <= popped_in;
      status_ff     <= status_in;
      rsp_pay_ff    <= rsp_pay_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_W'({rsp_cnt_ff, rsp_pay_ff});
   assign rsp_tuser  = {(rsp_cnt_ff == '0), rsp_status_ff};

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");
   a_push_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_PUSHED |-> rsp_cnt_ff != '0)
      else $error("push reported with empty queue");
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_EMPTY |-> rsp_cnt_ff == '0)
      else $error("empty pop with entries held");
   a_full_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_FULL |-> rsp_cnt_ff == CW'(CAPACITY))
      else $error("push refused below capacity");
   a_cnt_hold_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE && !req_fire |=> $stable(cnt_ff))
      else $error("count changed while idle");
`endif
endmodule
`default_nettype wire

// File: rtl/smpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module smpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for the stable max-priority queue core.
`timescale 1ns / 100ps
`default_nettype none
module tb;
   import smpq_pkg::*;

   localparam int CAP    = CAPACITY_DEF;
   localparam int IN_W   = 32;
   localparam int OUT_W  = 24;
   localparam int LIMIT  = 2000000;

   typedef struct packed {
      logic        func;
      logic [15:0] prio;
      logic [15:0] tag;
   } req_item_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] tag;
      logic [4:0]  count;
      logic        empty;
   } rsp_item_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [IN_W-1:0]  req_tdata = '0;
   logic             req_tuser = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [OUT_W-1:0] rsp_tdata;
   logic [2:0]       rsp_tuser;

   stable_max_priority_queue_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always #5 clock = ~clock;

   // predictor state: sorted in serving order
   logic signed [15:0] q_prio [CAP];
   logic [15:0]        q_tag [CAP];
   int                 q_count = 0;

   req_item_type pending_reqs[$];
   rsp_item_type expected_rsps[$];
   int        errors = 0;
   int        cycles = 0;
   int        gap = 0;
   int        hold = 0;
   bit        stim_done = 0;
   bit        drain_hold = 0;

   function automatic rsp_item_type queue_step(req_item_type it);
      rsp_item_type r;
      int pos;
      r.tag = '0;
      if (it.func == FUNC_PUSH) begin
         if (q_count >= CAP) begin
            r.status = STATUS_FULL;
         end else begin
            pos = 0;
            while (pos < q_count && q_prio[pos] >= $signed(it.prio)) pos++;
            for (int i = q_count; i > pos; i--) begin
               q_prio[i] = q_prio[i-1];
               q_tag[i]  = q_tag[i-1];
            end
            q_prio[pos] = it.prio;
            q_tag[pos]  = it.tag;
            q_count++;
            r.status = STATUS_PUSHED;
         end
      end else if (q_count == 0) begin
         r.status = STATUS_EMPTY;
      end else begin
         r.tag = q_tag[0];
         for (int i = 0; i + 1 < q_count; i++) begin
            q_prio[i] = q_prio[i+1];
            q_tag[i]  = q_tag[i+1];
         end
         q_count--;
         r.status = STATUS_POPPED;
      end
      r.count = q_count[4:0];
      r.empty = (q_count == 0);
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic req_item_type mk(logic f, logic [15:0] p, logic [15:0] t);
      req_item_type it;
      it.func = f; it.prio = p; it.tag = t;
      return it;
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_rsps.push_back(queue_step(pending_reqs.pop_front()));
            gap = pick_gap();
         end
         if (drain_hold && expected_rsps.size() != 0) begin
            req_tvalid <= 1'b0;
         end else if (gap > 0 && !(req_tvalid && !req_tready)) begin
            gap = gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tuser  <= pending_reqs[0].func;
            req_tdata  <= {pending_reqs[0].tag, pending_reqs[0].prio};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected item", rsp_tuser, 0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_tuser[1:0] != want.status)
                  report_mismatch("status", rsp_tuser[1:0], want.status);
               if (rsp_tdata[15:0] != want.tag)
                  report_mismatch("payload", rsp_tdata[15:0], want.tag);
               if (rsp_tdata[20:16] != want.count)
                  report_mismatch("count", rsp_tdata[20:16], want.count);
               if (rsp_tuser[2] != want.empty)
                  report_mismatch("is_empty", rsp_tuser[2], want.empty);
            end
         end
         if (hold > 0) begin
            hold <= hold - 1;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 99) < 25) begin
            hold <= pick_gap();
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int n, bias, burst;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pop, extremes, ties, fill past full, drain past empty
      pending_reqs.push_back(mk(FUNC_POP, 16'h0000, 16'h0000));
      pending_reqs.push_back(mk(FUNC_PUSH, 16'h8000, 16'hFFFF));
      pending_reqs.push_back(mk(FUNC_PUSH, 16'h7FFF, 16'h0000));
      pending_reqs.push_back(mk(FUNC_PUSH, 16'h0005, 16'h0001));
      pending_reqs.push_back(mk(FUNC_PUSH, 16'h0005, 16'h0002));
      pending_reqs.push_back(mk(FUNC_PUSH, 16'hFFFF, 16'hAAAA));
      pending_reqs.push_back(mk(FUNC_PUSH, 16'h0005, 16'h0003));
      for (int i = 0; i < 11; i++)
         pending_reqs.push_back(mk(FUNC_PUSH, 16'($urandom_range(0, 3)), 16'(16'h5555 ^ i)));
      for (int i = 0; i < 18; i++)
         pending_reqs.push_back(mk(FUNC_POP, 16'hFFFF, 16'hFFFF));

      // idle pause: wait for every result
      wait (pending_reqs.size() == 0);
      drain_hold = 1;
      wait (expected_rsps.size() == 0);
      drain_hold = 0;

      n = 0;
      while (n < 1800) begin
         bias = $urandom_range(20, 80);   // push share in percent
         burst = $urandom_range(10, 60);
         for (int i = 0; i < burst; i++) begin
            logic [15:0] p;
            p = ($urandom_range(0, 1)) ? 16'($urandom_range(0, 5)) : 16'($urandom);
            pending_reqs.push_back(mk($urandom_range(0, 99) >= bias, p, 16'($urandom)));
         end
         n += burst;
         wait (pending_reqs.size() < 8);
      end

      wait (pending_reqs.size() == 0 && !req_tvalid && expected_rsps.size() == 0);
      repeat (60) @(posedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
`default_nettype wire

// File: files.f
rtl/smpq_pkg.sv
rtl/smpq_ram.sv
rtl/stable_max_priority_queue_core.sv
verif/tb.sv
